// File: hw/rtl/mrc_pkg.sv
// Shared types, constants and CRC/scaling functions for the Modbus response checker.
// No dependencies; every other file imports this package.
`default_nettype none

package mrc_pkg;

    localparam int BYTE_W      = 8;
    localparam int USED_BYTES  = 15;
    localparam int CRC_SPAN    = 13;
    localparam int SNAP_SIX    = 6;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int TEMP_W      = 6;
    localparam int VOLT_W      = 13;
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] FN_READ         = 8'h03;
    localparam logic [BYTE_W-1:0] FN_WRITE        = 8'h06;
    localparam logic [BYTE_W-1:0] READ_BYTE_COUNT = 8'h0A;
    localparam logic [BYTE_W-1:0] HIGH_BYTE_MAX   = 8'h01;

    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [CFG_IDX_W-1:0] REG_EXP_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_VALUE = 2'd1;

    localparam logic [15:0]       EXP_ADDR_RST  = 16'd2;
    localparam logic [15:0]       EXP_VALUE_RST = 16'd0;
    localparam logic [VOLT_W-1:0] VOLT_RST      = 13'd10;
    localparam logic [VOLT_W-1:0] CURR_RST      = 13'd20;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_FUNC,
        ST_READ_CRC,
        ST_BYTE_COUNT,
        ST_RANGE,
        ST_WRITE_CRC,
        ST_ECHO_MISMATCH
    } t_status;

    typedef struct packed {
        logic [USED_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [15:0]                       crc;
        logic [15:0]                       crc6;
        logic [15:0]                       crc13;
        logic [CNT_W-1:0]                  cnt;
    } t_frame_rec;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [VOLT_W-1:0] div10(input logic [15:0] x);
        logic [32:0] p;
        p = {17'd0, x} * {16'd0, DIV10_MUL};
        return p[DIV10_SHIFT +: VOLT_W];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrc_if.sv
// Valid/ready channel interfaces: received bytes, results and configuration writes.
// Depends on mrc_pkg for field widths.
`default_nettype none

interface mrc_in_if import mrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_out_if import mrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [15:0]       alarm_word;
    logic [TEMP_W-1:0] water_temp;
    logic [TEMP_W-1:0] setpoint;
    logic [VOLT_W-1:0] voltage;
    logic [VOLT_W-1:0] current;
    logic              system_on;
    logic              link_released;

    modport source (output valid, output status, output alarm_word, output water_temp,
                    output setpoint, output voltage, output current, output system_on,
                    output link_released, input ready);
    modport sink   (input valid, input status, input alarm_word, input water_temp,
                    input setpoint, input voltage, input current, input system_on,
                    input link_released, output ready);
endinterface

interface mrc_cfg_if import mrc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mrc_front.sv
// Front end: takes bytes, buffers the frame, runs the CRC and snapshots,
// and hands a frame record to the queue at frame end. Depends on mrc_pkg, mrc_if.
`default_nettype none

module mrc_front import mrc_pkg::*; #(
    parameter int FRAME_BUFFER_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mrc_in_if.sink          i_in,
    input  wire logic       i_full,
    output logic            o_push,
    output t_frame_rec      o_rec
);

    localparam int POS_W = $clog2(FRAME_BUFFER_DEPTH + 1);

    logic [POS_W-1:0]                  r_pos, n_pos;
    logic [USED_BYTES-1:0][BYTE_W-1:0] r_bytes, n_bytes;
    logic [15:0]                       r_crc, n_crc;
    logic [15:0]                       r_crc6, n_crc6;
    logic [15:0]                       r_crc13, n_crc13;
    logic [15:0]                       crc_base;
    logic [CNT_W-1:0]                  absorbed;
    logic                              start, in_buf, in_crc, accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        start    = (r_pos == '0);
        in_buf   = (r_pos < POS_W'(FRAME_BUFFER_DEPTH));
        in_crc   = (r_pos < POS_W'(CRC_SPAN));
        n_bytes  = start ? '0 : r_bytes;
        for (int k = 0; k < USED_BYTES; k++) begin
            if (in_buf && r_pos == POS_W'(k)) begin
                n_bytes[k] = i_in.rx_byte;
            end
        end
        crc_base = start ? CRC_INIT : r_crc;
        n_crc    = in_crc ? crc_feed(crc_base, i_in.rx_byte) : crc_base;
        n_crc6   = (r_pos == POS_W'(SNAP_SIX - 1)) ? n_crc : r_crc6;
        n_crc13  = (r_pos == POS_W'(CRC_SPAN - 1)) ? n_crc : r_crc13;
        n_pos    = in_buf ? r_pos + POS_W'(1) : r_pos;
        absorbed = (n_pos < POS_W'(CRC_SPAN)) ? n_pos[CNT_W-1:0] : CNT_W'(CRC_SPAN);
    end

    assign o_push      = accept && i_in.frame_end;
    assign o_rec.bytes = n_bytes;
    assign o_rec.crc   = n_crc;
    assign o_rec.crc6  = n_crc6;
    assign o_rec.crc13 = n_crc13;
    assign o_rec.cnt   = absorbed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= i_in.frame_end ? '0 : n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes <= n_bytes;
            r_crc   <= n_crc;
            r_crc6  <= n_crc6;
            r_crc13 <= n_crc13;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mrc_queue.sv
// Two-entry frame record queue between front and back end.
// Depends on mrc_pkg.
`default_nettype none

module mrc_queue import mrc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_frame_rec i_rec,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_frame_rec      o_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_QW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hw/rtl/mrc_back.sv
// Back end: pads short-frame CRCs, checks the frame, scales values and holds results.
// Depends on mrc_pkg, mrc_if.
`default_nettype none

module mrc_back import mrc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_frame_rec  i_q_rec,
    output logic             o_pop,
    input  wire logic [15:0] i_exp_addr,
    input  wire logic [15:0] i_exp_value,
    mrc_out_if.source        o_out
);

    typedef struct packed {
        t_status     status;
        logic        released;
        logic        upd_read;
        logic        upd_sys;
        logic        sys_val;
        logic [15:0] alarm;
        logic [15:0] temp_raw;
        logic [15:0] set_raw;
        logic [15:0] volt_raw;
        logic [15:0] curr_raw;
    } t_eval;

    logic        r_a_busy;
    t_frame_rec  r_a;
    logic [15:0] pad_crc;
    logic        a_done, a_fire;

    logic        r_b_valid;
    t_eval       r_b, ev;
    logic        b_fire, b_free;

    logic [VOLT_W-1:0] q_temp, q_set, q_volt, q_curr;

    logic              r_o_valid;
    t_status           r_o_status;
    logic              r_o_released;
    logic [15:0]       r_alarm;
    logic [TEMP_W-1:0] r_temp, r_set;
    logic [VOLT_W-1:0] r_volt, r_curr;
    logic              r_sys_on;

    logic [USED_BYTES-1:0][BYTE_W-1:0] b;

    assign pad_crc = crc_feed(r_a.crc, 8'h00);
    assign a_done  = r_a_busy && (r_a.cnt == CNT_W'(CRC_SPAN));
    assign b_fire  = r_b_valid && (!r_o_valid || o_out.ready);
    assign b_free  = !r_b_valid || b_fire;
    assign a_fire  = a_done && b_free;
    assign o_pop   = i_q_valid && (!r_a_busy || a_fire);
    assign b       = r_a.bytes;

    always_comb begin
        ev          = '0;
        ev.status   = ST_OK;
        ev.alarm    = {b[3], b[4]};
        ev.temp_raw = {b[5], b[6]};
        ev.set_raw  = {b[7], b[8]};
        ev.volt_raw = {b[9], b[10]};
        ev.curr_raw = {b[11], b[12]};
        ev.sys_val  = ({b[4], b[5]} != 16'h0000);
        priority if (b[1] == FN_READ) begin
            if (r_a.crc13[7:0] != b[13] || r_a.crc13[15:8] != b[14]) begin
                ev.status = ST_READ_CRC;
            end else if (b[2] != READ_BYTE_COUNT) begin
                ev.status = ST_BYTE_COUNT;
            end else if (b[5] > HIGH_BYTE_MAX || b[7] > HIGH_BYTE_MAX) begin
                ev.status = ST_RANGE;
            end else begin
                ev.upd_read = 1'b1;
                ev.released = 1'b1;
            end
        end else if (b[1] == FN_WRITE) begin
            if (r_a.crc6[7:0] != b[6] || r_a.crc6[15:8] != b[7]) begin
                ev.status = ST_WRITE_CRC;
            end else begin
                ev.released = 1'b1;
                if ({b[2], b[3]} != i_exp_addr || {b[4], b[5]} != i_exp_value) begin
                    ev.status = ST_ECHO_MISMATCH;
                end else begin
                    ev.upd_sys = 1'b1;
                end
            end
        end else begin
            ev.status = ST_BAD_FUNC;
        end
    end

    assign q_temp = div10(r_b.temp_raw);
    assign q_set  = div10(r_b.set_raw);
    assign q_volt = div10(r_b.volt_raw);
    assign q_curr = div10(r_b.curr_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_busy  <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_alarm   <= '0;
            r_temp    <= '0;
            r_set     <= '0;
            r_volt    <= VOLT_RST;
            r_curr    <= CURR_RST;
            r_sys_on  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a_busy <= 1'b1;
            end else if (a_fire) begin
                r_a_busy <= 1'b0;
            end
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (b_fire && r_b.upd_read) begin
                r_alarm <= r_b.alarm;
                r_temp  <= q_temp[TEMP_W-1:0];
                if (q_set != '0) begin
                    r_set <= q_set[TEMP_W-1:0];
                end
                r_volt  <= q_volt;
                r_curr  <= q_curr;
            end
            if (b_fire && r_b.upd_sys) begin
                r_sys_on <= r_b.sys_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a <= i_q_rec;
        end else if (r_a_busy && !a_done) begin
            r_a.crc <= pad_crc;
            if (r_a.cnt == CNT_W'(SNAP_SIX - 1)) begin
                r_a.crc6 <= pad_crc;
            end
            if (r_a.cnt == CNT_W'(CRC_SPAN - 1)) begin
                r_a.crc13 <= pad_crc;
            end
            r_a.cnt <= r_a.cnt + CNT_W'(1);
        end
        if (a_fire) begin
            r_b <= ev;
        end
        if (b_fire) begin
            r_o_status   <= r_b.status;
            r_o_released <= r_b.released;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.alarm_word    = r_alarm;
    assign o_out.water_temp    = r_temp;
    assign o_out.setpoint      = r_set;
    assign o_out.voltage       = r_volt;
    assign o_out.current       = r_curr;
    assign o_out.system_on     = r_sys_on;
    assign o_out.link_released = r_o_released;

    a_release_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_released ==
            (r_o_status == ST_OK || r_o_status == ST_ECHO_MISMATCH)))
        else $error("link release disagrees with status");

    a_pad_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_busy && !a_done) |=> (r_a.cnt == $past(r_a.cnt) + CNT_W'(1)))
        else $error("CRC padding did not advance");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire |=> r_o_valid) else $error("result lost on output load");

endmodule

`default_nettype wire

// File: hw/rtl/modbus_response_checker.sv
// Path: the frame record goes into the queue, then the back end's padding stage (zero padding of the
// CRC per missing byte below thirteen), then the check register and the output register.
// Throughput: one byte per cycle while the queue is not full; the two-entry frame queue and
// output register let frames of thirteen or more bytes complete back to back.
// Reset (synchronous, active low) restores buffer position, held values and registers;
// no clearing pass. Depends on mrc_pkg, mrc_if, mrc_front, mrc_queue, mrc_back.
`default_nettype none

module modbus_response_checker import mrc_pkg::*; #(
    parameter int FRAME_BUFFER_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrc_in_if.sink     i_in,
    mrc_cfg_if.sink    i_cfg,
    mrc_out_if.source  o_out
);

    logic [15:0] r_exp_address;
    logic [15:0] r_exp_value;
    logic        push, full, pop, q_valid;
    t_frame_rec  push_rec, q_rec;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_address <= EXP_ADDR_RST;
            r_exp_value   <= EXP_VALUE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_EXP_ADDR:  r_exp_address <= i_cfg.data;
                REG_EXP_VALUE: r_exp_value   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    mrc_front #(
        .FRAME_BUFFER_DEPTH(FRAME_BUFFER_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    mrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    mrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_pop       (pop),
        .i_exp_addr  (r_exp_address),
        .i_exp_value (r_exp_value),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: tb/mrc_result_checker.sv
`timescale 1ns / 100ps
// Watches the byte, result and register channels of the Modbus response checker.
// It predicts the verdict of every frame and compares it with each result taken.
// Depends on mrc_pkg and the channel interfaces in mrc_if.
module mrc_result_checker import mrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mrc_in_if    i_in,
    mrc_out_if   i_out,
    mrc_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending
);

    localparam int BUF_DEPTH   = 16;
    localparam int SCALE       = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_status           status;
        logic [15:0]       alarm;
        logic [TEMP_W-1:0] temp;
        logic [TEMP_W-1:0] setp;
        logic [VOLT_W-1:0] volt;
        logic [VOLT_W-1:0] curr;
        logic              sys_on;
        logic              released;
    } t_verdict;

    logic [7:0]  frame_buf [BUF_DEPTH];
    int          fill;
    logic [15:0] crc_run;
    logic [15:0] crc_six;
    logic [15:0] crc_thirteen;
    logic [15:0] alarm_h;
    logic [15:0] temp_h;
    logic [15:0] setp_h;
    logic [15:0] volt_h;
    logic [15:0] curr_h;
    logic        sys_on_h;
    logic [15:0] cfg_addr;
    logic [15:0] cfg_value;
    t_verdict    awaited_verdicts [$];
    int          result_no;
    int          mismatches;

    // bit-serial form: feedback is the crc lsb xor the incoming data bit
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] word_at(input int i);
        return {frame_buf[i], frame_buf[i+1]};
    endfunction

    task automatic absorb(input int idx, input logic [7:0] b);
        crc_run = crc_byte(crc_run, b);
        if (idx == SNAP_SIX - 1) begin
            crc_six = crc_run;
        end
        if (idx == CRC_SPAN - 1) begin
            crc_thirteen = crc_run;
        end
    endtask

    task automatic reset_model();
        foreach (frame_buf[i]) begin
            frame_buf[i] = 8'h00;
        end
        fill         = 0;
        crc_run      = CRC_INIT;
        crc_six      = CRC_INIT;
        crc_thirteen = CRC_INIT;
        alarm_h      = 16'd0;
        temp_h       = 16'd0;
        setp_h       = 16'd0;
        volt_h       = 16'(VOLT_RST);
        curr_h       = 16'(CURR_RST);
        sys_on_h     = 1'b0;
        cfg_addr     = EXP_ADDR_RST;
        cfg_value    = EXP_VALUE_RST;
        awaited_verdicts.delete();
    endtask

    task automatic judge_byte(input logic [7:0] b, input logic fend);
        int          pad;
        logic [15:0] sp;
        t_verdict    v;
        if (fill == 0) begin
            foreach (frame_buf[i]) begin
                frame_buf[i] = 8'h00;
            end
            crc_run      = CRC_INIT;
            crc_six      = CRC_INIT;
            crc_thirteen = CRC_INIT;
        end
        if (fill < BUF_DEPTH) begin
            frame_buf[fill] = b;
            if (fill < CRC_SPAN) begin
                absorb(fill, b);
            end
            fill++;
        end
        if (!fend) begin
            return;
        end
        // short frames: missing bytes count as zero in the crc
        for (pad = fill; pad < CRC_SPAN; pad++) begin
            absorb(pad, 8'h00);
        end
        v.status   = ST_OK;
        v.released = 1'b0;
        case (frame_buf[1])
            FN_READ: begin
                if (crc_thirteen != {frame_buf[14], frame_buf[13]}) begin
                    v.status = ST_READ_CRC;
                end else if (frame_buf[2] != READ_BYTE_COUNT) begin
                    v.status = ST_BYTE_COUNT;
                end else if (frame_buf[5] > HIGH_BYTE_MAX || frame_buf[7] > HIGH_BYTE_MAX) begin
                    v.status = ST_RANGE;
                end else begin
                    sp      = 16'(word_at(7) / SCALE);
                    alarm_h = word_at(3);
                    temp_h  = 16'(word_at(5) / SCALE);
                    if (sp != 16'd0) begin
                        setp_h = sp;
                    end
                    volt_h     = 16'(word_at(9) / SCALE);
                    curr_h     = 16'(word_at(11) / SCALE);
                    v.released = 1'b1;
                end
            end
            FN_WRITE: begin
                if (crc_six != {frame_buf[7], frame_buf[6]}) begin
                    v.status = ST_WRITE_CRC;
                end else begin
                    if (word_at(2) != cfg_addr || word_at(4) != cfg_value) begin
                        v.status = ST_ECHO_MISMATCH;
                    end else begin
                        sys_on_h = (word_at(4) != 16'd0);
                    end
                    v.released = 1'b1;
                end
            end
            default: begin
                v.status = ST_BAD_FUNC;
            end
        endcase
        v.alarm  = alarm_h;
        v.temp   = temp_h[TEMP_W-1:0];
        v.setp   = setp_h[TEMP_W-1:0];
        v.volt   = volt_h[VOLT_W-1:0];
        v.curr   = curr_h[VOLT_W-1:0];
        v.sys_on = sys_on_h;
        awaited_verdicts.push_back(v);
        fill = 0;
    endtask

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result %0d %s: expected %0h, got %0h", result_no, field, want, got);
            end
        end
    endtask

    task automatic check_result();
        t_verdict v;
        if (awaited_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result %0d: no frame end awaiting a result", result_no);
            end
        end else begin
            v = awaited_verdicts.pop_front();
            report_field("status", 16'(v.status), 16'(i_out.status));
            report_field("alarm_word", v.alarm, i_out.alarm_word);
            report_field("water_temp", 16'(v.temp), 16'(i_out.water_temp));
            report_field("setpoint", 16'(v.setp), 16'(i_out.setpoint));
            report_field("voltage", 16'(v.volt), 16'(i_out.voltage));
            report_field("current", 16'(v.curr), 16'(i_out.current));
            report_field("system_on", 16'(v.sys_on), 16'(i_out.system_on));
            report_field("link_released", 16'(v.released), 16'(i_out.link_released));
        end
        result_no++;
    endtask

    initial begin
        mismatches = 0;
        result_no  = 0;
        reset_model();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_EXP_ADDR:  cfg_addr = i_cfg.data;
                    REG_EXP_VALUE: cfg_value = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                judge_byte(i_in.rx_byte, i_in.frame_end);
            end
            if (i_out.valid && i_out.ready) begin
                check_result();
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= awaited_verdicts.size();
    end

endmodule

// File: tb/modbus_response_checker_test.sv
`timescale 1ns / 100ps
// Top of the Modbus response checker testbench: clock, reset, frame stimulus and verdict.
// Depends on mrc_pkg, mrc_if, the block itself and mrc_result_checker.
module modbus_response_checker_test;
    import mrc_pkg::*;

    localparam int LIMIT         = 400000;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_GAP       = 12;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;

    bit          steady;
    int          hold_off;
    int          sent;
    logic [15:0] cur_addr;
    logic [15:0] cur_value;
    logic [7:0]  frame_q [$];

    mrc_in_if  in_ch ();
    mrc_out_if out_ch ();
    mrc_cfg_if cfg_ch ();

    modbus_response_checker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    mrc_result_checker i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("modbus_response_checker test failed");
        $finish;
    end

    // result side
    initial begin
        int gap;
        forever begin
            if (hold_off > 0) begin
                gap      = hold_off;
                hold_off = 0;
            end else begin
                gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fend);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.rx_byte   <= b;
        in_ch.frame_end <= fend;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            send_item(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i]) begin
            c = crc_feed(c, frame_q[i]);
        end
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    task automatic build_read(input logic [7:0] dev, input logic [7:0] count,
                              input logic [15:0] alarm, input logic [15:0] tw,
                              input logic [15:0] sw, input logic [15:0] vw,
                              input logic [15:0] cw);
        frame_q = {dev, FN_READ, count, alarm[15:8], alarm[7:0], tw[15:8], tw[7:0],
                   sw[15:8], sw[7:0], vw[15:8], vw[7:0], cw[15:8], cw[7:0]};
        append_crc();
    endtask

    task automatic build_write(input logic [7:0] dev, input logic [15:0] reg_addr,
                               input logic [15:0] reg_value);
        frame_q = {dev, FN_WRITE, reg_addr[15:8], reg_addr[7:0],
                   reg_value[15:8], reg_value[7:0]};
        append_crc();
    endtask

    // mostly within the allowed high-byte range
    function automatic logic [15:0] ranged_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 99) < 80) begin
            w[15:8] = 8'($urandom_range(0, 1));
        end
        return w;
    endfunction

    task automatic random_frame();
        int          pick;
        int          cut;
        int          idx;
        logic [7:0]  count;
        logic [15:0] sw;
        logic [15:0] ra;
        logic [15:0] rv;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            count = ($urandom_range(0, 99) < 8) ? 8'($urandom) : READ_BYTE_COUNT;
            sw    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 9)) : ranged_word();
            build_read(8'($urandom), count, 16'($urandom), ranged_word(), sw,
                       16'($urandom), 16'($urandom));
        end else if (pick < 85) begin
            ra = cur_addr;
            rv = cur_value;
            if ($urandom_range(0, 99) < 25) begin
                if ($urandom_range(0, 1) == 0) begin
                    ra = ra ^ (16'h1 << $urandom_range(0, 15));
                end else begin
                    rv = rv ^ (16'h1 << $urandom_range(0, 15));
                end
            end
            build_write(8'($urandom), ra, rv);
        end else begin
            frame_q.delete();
            repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
            if (frame_q.size() > 1 && $urandom_range(0, 99) < 30) begin
                frame_q[1] = $urandom_range(0, 1) ? FN_READ : FN_WRITE;
            end
            return;
        end
        cut = $urandom_range(0, 99);
        if (cut < 10) begin
            idx          = $urandom_range(0, frame_q.size() - 1);
            frame_q[idx] = frame_q[idx] ^ (8'h1 << $urandom_range(0, 7));
        end else if (cut < 18) begin
            idx = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > idx) begin
                void'(frame_q.pop_back());
            end
        end else if (cut < 26) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
        end
    endtask

    // wait until every frame has been answered and the back end has drained
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] reg_addr, input logic [15:0] reg_value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_EXP_ADDR;
        cfg_ch.data  <= reg_addr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_EXP_VALUE;
        cfg_ch.data  <= reg_value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_addr  = reg_addr;
        cur_value = reg_value;
    endtask

    initial begin
        int start;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.rx_byte   <= 8'h00;
        in_ch.frame_end <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_EXP_ADDR;
        cfg_ch.data     <= 16'h0000;
        steady    = 1'b0;
        hold_off  = 0;
        sent      = 0;
        cur_addr  = EXP_ADDR_RST;
        cur_value = EXP_VALUE_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale read, echo against reset registers, one-byte frame
        build_read(8'hFF, READ_BYTE_COUNT, 16'hFFFF, 16'h01FF, 16'h01FF, 16'hFFFF, 16'hFFFF);
        send_frame();
        build_write(8'h01, cur_addr, cur_value);
        send_frame();
        send_item(8'h00, 1'b1);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_regs(16'h0000, 16'h0000);
                1: write_regs(16'hFFFF, 16'hFFFF);
                2: write_regs(16'h0002, 16'h0001);
                default: write_regs(16'($urandom),
                                    ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
            endcase
            steady = (phase == 2);
            if (phase == 2) begin
                hold_off = LONG_HOLD;
            end
            start = sent;
            while (sent - start < PHASE_ITEMS) begin
                random_frame();
                send_frame();
            end
            steady = 1'b0;
            settle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("modbus_response_checker test passed");
        end else begin
            $display("modbus_response_checker test failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_if.sv
hw/rtl/mrc_front.sv
hw/rtl/mrc_queue.sv
hw/rtl/mrc_back.sv
hw/rtl/modbus_response_checker.sv
tb/mrc_result_checker.sv
tb/modbus_response_checker_test.sv
